// ----- rtl/rolling_sum_substring_search_macros.svh -----
// Assertion macros shared by the substring search RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ROLLING_SUM_SUBSTRING_SEARCH_MACROS_SVH
`define ROLLING_SUM_SUBSTRING_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rss_pkg.sv -----
// Package for the rolling-sum substring search block.
// Holds field widths, register index codes and the result beat type.
`timescale 1ns / 1ps

package rss_pkg;

   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 16;
   localparam int LEN_REG_W  = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_SEL_W  = 2;

   localparam logic [REG_SEL_W-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [REG_SEL_W-1:0] REG_BYTES_LOW      = 2'd1;
   localparam logic [REG_SEL_W-1:0] REG_BYTES_HIGH     = 2'd2;

   localparam logic [LEN_REG_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] match_index;
      logic               position_overflow;
   } rss_result_type;

endpackage

// ----- rtl/rolling_sum_substring_search.sv -----
// Top level of the rolling-sum substring search block.
// Depends on rss_pkg, rss_match and rss_out_queue.
// One text byte is taken per beat; req_ready stays high in every cycle while
// the two-entry result queue has room, so a byte can be accepted each clock.
// A byte's result, if any, is visible on the rsp port the cycle after it is
// accepted when no earlier result is still waiting in the queue; the pattern
// compare runs in parallel over the window between the text registers and the
// queue. No clearing pass follows reset.
`timescale 1ns / 1ps
`include "rolling_sum_substring_search_macros.svh"

module rolling_sum_substring_search
   import rss_pkg::*;
#(
   parameter int MAX_PATTERN   = 16,
   parameter int POSITION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_text_byte,
   input  logic                  req_text_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [INDEX_W-1:0]    rsp_match_index,
   output logic                  rsp_position_overflow,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int P     = POSITION_BITS;

   logic [LEN_REG_W-1:0]  cfg_len_ff;
   logic [CSR_DATA_W-1:0] cfg_low_ff;
   logic [CSR_DATA_W-1:0] cfg_high_ff;
   logic                  csr_write;
   logic [REG_SEL_W-1:0]  reg_sel;

   logic [MAX_PATTERN*BYTE_W-1:0] window_ff, window_in;
   logic [P:0]                    text_pos_ff, text_pos_in;
   logic                          reported_ff, reported_in;
   logic                          overflow_ff, overflow_in;

   logic [LEN_W-1:0] used_len;
   logic             accept;
   logic             all_equal;
   logic [P-1:0]     pos;
   logic [P:0]       pos_plus1;
   logic [P:0]       start;
   logic             overflow_now;
   logic             match;
   logic             emit;
   logic             queue_full;
   rss_result_type   result;
   rss_result_type   head;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1 -: REG_SEL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff  <= PATTERN_LENGTH_RESET;
         cfg_low_ff  <= '0;
         cfg_high_ff <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            REG_PATTERN_LENGTH: cfg_len_ff <= csr_pwdata[LEN_REG_W-1:0];
            REG_BYTES_LOW:      cfg_low_ff <= csr_pwdata;
            REG_BYTES_HIGH:     cfg_high_ff <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_W'(cfg_len_ff);
         REG_BYTES_LOW:      csr_prdata = cfg_low_ff;
         REG_BYTES_HIGH:     csr_prdata = cfg_high_ff;
         default:            csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (cfg_len_ff == '0) begin
         used_len = LEN_W'(1);
      end else if (int'(cfg_len_ff) > MAX_PATTERN) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = LEN_W'(cfg_len_ff);
      end
   end

   // Search datapath.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign window_in = (MAX_PATTERN*BYTE_W)'({window_ff, req_text_byte});

   rss_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .window_i     (window_in),
      .bytes_low_i  (cfg_low_ff),
      .bytes_high_i (cfg_high_ff),
      .len_i        (used_len),
      .all_equal_o  (all_equal)
   );

   assign overflow_now = overflow_ff || text_pos_ff[P];
   assign pos          = text_pos_ff[P] ? '1 : text_pos_ff[P-1:0];
   assign pos_plus1    = {1'b0, pos} + (P+1)'(1);
   assign start        = pos_plus1 - (P+1)'(used_len);
   assign match        = !reported_ff && (pos_plus1 >= (P+1)'(used_len)) && all_equal;
   assign emit         = match || (req_text_last && !reported_ff);

   always_comb begin
      result.found             = match;
      result.match_index       = match ? INDEX_W'(start) : '0;
      result.position_overflow = overflow_now;
   end

   always_comb begin
      if (req_text_last) begin
         text_pos_in = '0;
         reported_in = 1'b0;
         overflow_in = 1'b0;
      end else begin
         text_pos_in = text_pos_ff[P] ? text_pos_ff : text_pos_ff + (P+1)'(1);
         reported_in = reported_ff || match;
         overflow_in = overflow_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         text_pos_ff <= '0;
         reported_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else if (accept) begin
         window_ff   <= req_text_last ? '0 : window_in;
         text_pos_ff <= text_pos_in;
         reported_ff <= reported_in;
         overflow_ff <= overflow_in;
      end
   end

   rss_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (accept && emit),
      .push_data_i (result),
      .full_o      (queue_full),
      .pop_ready_i (rsp_ready),
      .valid_o     (rsp_valid),
      .data_o      (head)
   );

   assign rsp_found             = head.found;
   assign rsp_match_index       = head.match_index;
   assign rsp_position_overflow = head.position_overflow;

   `RSS_ASSERT_SAME(a_one_report, clock, reset, accept && reported_ff, !emit, "second result in one text")
   `RSS_ASSERT_NEXT(a_overflow_sticky, clock, reset, overflow_ff && !(accept && req_text_last), overflow_ff, "overflow flag dropped mid-text")
   `RSS_ASSERT_SAME(a_miss_index_zero, clock, reset, accept && emit && !match, result.match_index == '0, "not-found beat with nonzero index")

endmodule

// ----- rtl/rss_match.sv -----
// Parallel window compare for the substring search block.
// Depends on rss_pkg for the byte width and the pattern register widths.
`timescale 1ns / 1ps

module rss_match
   import rss_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  logic [MAX_PATTERN*BYTE_W-1:0]    window_i,
   input  logic [CSR_DATA_W-1:0]            bytes_low_i,
   input  logic [CSR_DATA_W-1:0]            bytes_high_i,
   input  logic [$clog2(MAX_PATTERN+1)-1:0] len_i,
   output logic                             all_equal_o
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [BYTE_W-1:0] pattern [MAX_PATTERN];
   logic [BYTE_W-1:0] window  [MAX_PATTERN];
   logic [IDX_W-1:0]  pidx;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         window[k] = window_i[k*BYTE_W +: BYTE_W];
         if (k < 8) begin
            pattern[k] = bytes_low_i[(k % 8)*BYTE_W +: BYTE_W];
         end else if (k < 16) begin
            pattern[k] = bytes_high_i[(k % 8)*BYTE_W +: BYTE_W];
         end else begin
            pattern[k] = '0;
         end
      end
   end

   // The newest byte sits at window slot 0 and lines up with the last
   // pattern byte in use. Full byte equality also implies equal sums.
   always_comb begin
      all_equal_o = 1'b1;
      pidx        = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pidx = IDX_W'(len_i - LEN_W'(j) - LEN_W'(1));
         if ((LEN_W'(j) < len_i) && (window[j] != pattern[pidx])) begin
            all_equal_o = 1'b0;
         end
      end
   end

endmodule

// ----- rtl/rss_out_queue.sv -----
// Two-entry result queue that decouples the search core from the result port.
// Depends on rss_pkg for the result beat type.
`timescale 1ns / 1ps
`include "rolling_sum_substring_search_macros.svh"

module rss_out_queue
   import rss_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_i,
   input  rss_result_type push_data_i,
   output logic           full_o,
   input  logic           pop_ready_i,
   output logic           valid_o,
   output rss_result_type data_o
);

   rss_result_type mem_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign valid_o = (count_ff != 2'd0);
   assign full_o  = (count_ff == 2'd2);
   assign data_o  = mem_ff[rd_ptr_ff];
   assign pop     = valid_o && pop_ready_i;

   always_comb begin
      wr_ptr_in = push_i ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push_i) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   `RSS_ASSERT_SAME(a_no_push_when_full, clock, reset, push_i, !full_o, "push into full queue")
   `RSS_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff != 2'd3, "queue count out of range")
   `RSS_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push_i, count_ff == $past(count_ff) - 2'd1, "pop did not drain an entry")

endmodule
